// ===== rtl/tlbflt_pkg.sv =====
// Shared types and constants for the FIFO/LRU translation buffer.
package tlbflt_pkg;

   // Request action codes
   localparam int ACT_W = 2;
   typedef enum logic [ACT_W-1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_FILL   = 2'd1,
      ACT_FLUSH  = 2'd2,
      ACT_RSVD   = 2'd3
   } action_type;

   // Control register file
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_ADDR_W-1:0] CSR_MODE = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SIZE = 1'b1;
   localparam logic [CSR_DATA_W-1:0] SIZE_RESET = 5'd4;

   // Datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_NONE       = 3'd0,
      OP_TOUCH      = 3'd1,
      OP_DROP_MATCH = 3'd2,
      OP_DROP_HEAD  = 3'd3,
      OP_INSERT     = 3'd4,
      OP_FLUSH      = 3'd5
   } op_type;

   typedef struct packed {
      logic   capture;   // latch the incoming request word
      op_type op;
      logic   load_rsp;  // move the result into the output register
   } dp_cmd_type;

   typedef struct packed {
      logic fill_match;  // a valid entry shares the fill page or frame
      logic at_limit;    // occupancy at or above the size limit
      logic rsp_free;    // output register can take a word this cycle
   } dp_stat_type;

endpackage

// ===== rtl/tlbflt_dpath.sv =====
// Entry storage, age ranks, search logic and output register.
module tlbflt_dpath
   import tlbflt_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int PAGE_BITS   = 20,
   parameter int FRAME_BITS  = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [ACT_W-1:0]      req_action,
   input  logic [PAGE_BITS-1:0]  req_page,
   input  logic [FRAME_BITS-1:0] req_frame,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_hit,
   output logic [FRAME_BITS-1:0] rsp_frame
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int LW = (CW > CSR_DATA_W) ? CW : CSR_DATA_W;

   logic                  mode_ff;
   logic [CSR_DATA_W-1:0] size_ff;

   logic [ACT_W-1:0]      req_action_ff;
   logic [PAGE_BITS-1:0]  req_page_ff;
   logic [FRAME_BITS-1:0] req_frame_ff;

   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [PAGE_BITS-1:0]   tag_ff  [MAX_ENTRIES];
   logic [PAGE_BITS-1:0]   tag_in  [MAX_ENTRIES];
   logic [FRAME_BITS-1:0]  frm_ff  [MAX_ENTRIES];
   logic [FRAME_BITS-1:0]  frm_in  [MAX_ENTRIES];
   logic [IW-1:0]          rank_ff [MAX_ENTRIES];
   logic [IW-1:0]          rank_in [MAX_ENTRIES];
   logic [CW-1:0]          count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [FRAME_BITS-1:0] rsp_frame_ff, rsp_frame_in;

   logic [MAX_ENTRIES-1:0] hit_vec, match_vec, head_vec;
   logic [IW-1:0]          hit_idx, match_idx, head_idx, free_idx, drop_idx;
   logic                   hit_any;
   logic [IW-1:0]          drop_rank, touch_rank, last_rank;
   logic [LW-1:0]          limit;
   logic                   res_hit;
   logic [FRAME_BITS-1:0]  res_frame;

   // Parallel compare across all slots, lowest index wins
   always_comb begin
      hit_idx   = '0;
      match_idx = '0;
      head_idx  = '0;
      free_idx  = '0;
      for (int s = 0; s < MAX_ENTRIES; s++) begin
         hit_vec[s]   = valid_ff[s] && (tag_ff[s] == req_page_ff);
         match_vec[s] = valid_ff[s] &&
                        ((tag_ff[s] == req_page_ff) || (frm_ff[s] == req_frame_ff));
         head_vec[s]  = valid_ff[s] && (rank_ff[s] == '0);
      end
      for (int s = MAX_ENTRIES - 1; s >= 0; s--) begin
         if (hit_vec[s])   hit_idx   = IW'(s);
         if (match_vec[s]) match_idx = IW'(s);
         if (head_vec[s])  head_idx  = IW'(s);
         if (!valid_ff[s]) free_idx  = IW'(s);
      end
   end

   assign hit_any = |hit_vec;

   // Size register clamped to 1..MAX_ENTRIES
   always_comb begin
      if (size_ff == '0) begin
         limit = LW'(1);
      end else if (LW'(size_ff) > LW'(MAX_ENTRIES)) begin
         limit = LW'(MAX_ENTRIES);
      end else begin
         limit = LW'(size_ff);
      end
   end

   assign stat.fill_match = |match_vec;
   assign stat.at_limit   = (LW'(count_ff) >= limit) && (count_ff != '0);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign drop_idx   = (cmd.op == OP_DROP_HEAD) ? head_idx : match_idx;
   assign drop_rank  = rank_ff[drop_idx];
   assign touch_rank = rank_ff[hit_idx];
   assign last_rank  = IW'(count_ff - CW'(1));

   // Entry and rank update
   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      frm_in   = frm_ff;
      rank_in  = rank_ff;
      count_in = count_ff;
      unique case (cmd.op) inside
         OP_TOUCH: begin
            if (mode_ff && hit_any) begin
               for (int s = 0; s < MAX_ENTRIES; s++) begin
                  if (valid_ff[s] && (rank_ff[s] > touch_rank)) begin
                     rank_in[s] = rank_ff[s] - IW'(1);
                  end
               end
               rank_in[hit_idx] = last_rank;
            end
         end
         OP_DROP_MATCH, OP_DROP_HEAD: begin
            for (int s = 0; s < MAX_ENTRIES; s++) begin
               if (valid_ff[s] && (rank_ff[s] > drop_rank)) begin
                  rank_in[s] = rank_ff[s] - IW'(1);
               end
            end
            valid_in[drop_idx] = 1'b0;
            count_in           = count_ff - CW'(1);
         end
         OP_INSERT: begin
            valid_in[free_idx] = 1'b1;
            tag_in[free_idx]   = req_page_ff;
            frm_in[free_idx]   = req_frame_ff;
            rank_in[free_idx]  = IW'(count_ff);
            count_in           = count_ff + CW'(1);
         end
         OP_FLUSH: begin
            valid_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Result: only a lookup reports a hit; lookups never change tags
   assign res_hit   = (req_action_ff == ACT_LOOKUP) && hit_any;
   assign res_frame = res_hit ? frm_ff[hit_idx] : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_frame_in = rsp_frame_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = res_hit;
         rsp_frame_in = res_frame;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         size_ff      <= SIZE_RESET;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_MODE: mode_ff <= csr_wdata[0];
               CSR_SIZE: size_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_action_ff <= req_action;
         req_page_ff   <= req_page;
         req_frame_ff  <= req_frame;
      end
      tag_ff       <= tag_in;
      frm_ff       <= frm_in;
      rank_ff      <= rank_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_frame_ff <= rsp_frame_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_frame  = rsp_frame_ff;

endmodule

// ===== rtl/tlbflt_ctrl.sv =====
// Sequencer for lookup, fill and flush operations.
module tlbflt_ctrl
   import tlbflt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [ACT_W-1:0] req_action,
   input  dp_stat_type      stat,
   output dp_cmd_type       cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_LOOKUP = 6'b000010,
      S_DROP   = 6'b000100,
      S_EVICT  = 6'b001000,
      S_FLUSH  = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd.capture  = 1'b0;
      cmd.op       = OP_NONE;
      cmd.load_rsp = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               unique case (req_action)
                  ACT_LOOKUP: state_in = S_LOOKUP;
                  ACT_FILL:   state_in = S_DROP;
                  ACT_FLUSH:  state_in = S_FLUSH;
                  default:    state_in = S_FINISH;
               endcase
            end
         end
         S_LOOKUP: begin
            cmd.op = OP_TOUCH;
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DROP: begin
            // one matching entry removed per cycle
            if (stat.fill_match) begin
               cmd.op = OP_DROP_MATCH;
            end else begin
               state_in = S_EVICT;
            end
         end
         S_EVICT: begin
            if (stat.at_limit) begin
               cmd.op = OP_DROP_HEAD;
            end else begin
               cmd.op = OP_INSERT;
               if (stat.rsp_free) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FLUSH: begin
            cmd.op = OP_FLUSH;
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/tlb_fifo_lru_translate.sv =====
// Top level of the fully associative FIFO/LRU page translation buffer.
//
//  channel  | dir | handshake                | payload
//  ---------+-----+--------------------------+-----------------------------------
//  req_     | in  | req_tvalid / req_tready  | action, page_number, fill_frame
//  rsp_     | out | rsp_tvalid / rsp_tready  | hit, frame_number
//  csr_     | in  | csr_we (no wait)         | csr_addr 0 mode, 1 size limit
//
//  A lookup is accepted, then compares and updates ranks in the lookup state.
//  A fill drops each entry matching its page or frame, then evicts queue heads,
//  one per cycle through the shared rank-update logic, and then inserts the entry.
//  A flush clears the table; the reserved action code goes straight to finish.
//  Reset clears all valid bits, the occupancy count and the output register.
//  A stalled rsp_ holds its word; the next word is accepted and worked on
//  meanwhile, and its result waits in the finish state until the register frees.
module tlb_fifo_lru_translate
   import tlbflt_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int PAGE_BITS   = 20,
   parameter int FRAME_BITS  = 20
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // action, page_number, fill_frame (low bit up), zero padded
   input  logic [((ACT_W+PAGE_BITS+FRAME_BITS+7)/8)*8-1:0] req_tdata,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // hit, frame_number (low bit up), zero padded
   output logic [((1+FRAME_BITS+7)/8)*8-1:0]          rsp_tdata,
   input  logic                                       csr_we,
   input  logic [CSR_ADDR_W-1:0]                      csr_addr,
   input  logic [CSR_DATA_W-1:0]                      csr_wdata
);

   localparam int RSP_W   = 1 + FRAME_BITS;
   localparam int RSP_PAD = ((RSP_W + 7) / 8) * 8;

   logic [ACT_W-1:0]      req_action;
   logic [PAGE_BITS-1:0]  req_page;
   logic [FRAME_BITS-1:0] req_frame;
   logic                  rsp_hit;
   logic [FRAME_BITS-1:0] rsp_frame;
   dp_cmd_type            cmd;
   dp_stat_type           stat;

   // request word unpack
   assign req_action = req_tdata[ACT_W-1:0];
   assign req_page   = req_tdata[ACT_W+PAGE_BITS-1:ACT_W];
   assign req_frame  = req_tdata[ACT_W+PAGE_BITS+FRAME_BITS-1:ACT_W+PAGE_BITS];

   tlbflt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd)
   );

   tlbflt_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .PAGE_BITS   (PAGE_BITS),
      .FRAME_BITS  (FRAME_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_action (req_action),
      .req_page   (req_page),
      .req_frame  (req_frame),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_hit    (rsp_hit),
      .rsp_frame  (rsp_frame)
   );

   // response word pack, hit in bit 0
   assign rsp_tdata = RSP_PAD'({rsp_frame, rsp_hit});

endmodule

// ===== rtl/tlbflt_check.sv =====
// Port-level checker for the translation buffer, bound to the top level.
module tlbflt_check
   import tlbflt_pkg::*;
#(
   parameter int FRAME_BITS  = 20
) (
   input logic                                            clock,
   input logic                                            reset,
   input logic                                            req_tvalid,
   input logic                                            req_tready,
   input logic                                            rsp_tvalid,
   input logic                                            rsp_tready,
   input logic [((1+FRAME_BITS+7)/8)*8-1:0]               rsp_tdata
);

   localparam int RSP_PAD = ((1 + FRAME_BITS + 7) / 8) * 8;

   // a miss or a non-lookup reports frame zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[FRAME_BITS:1] == '0))
      else $error("miss word carries a nonzero frame");

   // reset leaves no word pending
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // one request in flight: the block is busy the cycle after it takes a word
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request accepted back to back");

   // a stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response word changed");

   // padding above the frame stays zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata >> (1 + FRAME_BITS)) == RSP_PAD'(0)))
      else $error("response padding not zero");

endmodule

bind tlb_fifo_lru_translate tlbflt_check #(
   .FRAME_BITS  (FRAME_BITS)
) u_tlbflt_check (.*);

// ===== tb/sv/tlb_fifo_lru_translate_tb.sv =====
// Self-checking testbench for the FIFO/LRU page translation buffer.
`timescale 1ns / 1ps

module tlb_fifo_lru_translate_tb;
   import tlbflt_pkg::*;

   localparam int SLOTS      = 16;
   localparam int PAGE_W     = 20;
   localparam int FRAME_W    = 20;
   localparam int REQ_W      = ((ACT_W + PAGE_W + FRAME_W + 7) / 8) * 8;
   localparam int RSP_W      = ((1 + FRAME_W + 7) / 8) * 8;
   localparam int N_DIRECTED = 21;
   localparam int N_PHASES   = 8;
   localparam int PHASE_WORDS = 190;
   // Quiet cycles after the last result before touching the registers.
   localparam int SETTLE     = 8;
   // Receiver hold-off: starts after this many results, lasts this long.
   localparam int HOLD_AT    = 300;
   localparam int HOLD_LEN   = 250;
   // Cycles with no word moving on either side before giving up. The slowest
   // legal gap is the hold-off above plus a full fill.
   localparam int STALL_LIMIT = 2000;

   typedef logic [PAGE_W-1:0]  page_type;
   typedef logic [FRAME_W-1:0] frame_type;

   typedef struct packed {
      logic      hit;
      frame_type frame;
   } xlat_type;

   // One row of the directed table. When typed is set, the listed outcome is
   // what gets checked; otherwise the predictor supplies it.
   typedef struct packed {
      action_type act;
      page_type   page;
      frame_type  frame;
      logic       typed;
      logic       hit;
      frame_type  frame_out;
   } dir_row_type;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Shadow copy of the translation table.
   logic      tbl_valid [SLOTS];
   page_type  tbl_page  [SLOTS];
   frame_type tbl_frame [SLOTS];
   int        tbl_age   [$];       // slots, oldest first
   logic      cfg_lru;
   logic [CSR_DATA_W-1:0] cfg_size;

   xlat_type  pending_xlat [$];     // translations still owed by the block
   int        mismatches;
   int        idle_cycles;

   tlb_fifo_lru_translate i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // action, page_number, fill_frame (low bit up), zero padded
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // hit, frame_number (low bit up), zero padded
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Directed words, run with the reset settings (FIFO, 4 entries).
   dir_row_type dir_rows [N_DIRECTED] = '{
      // empty table: both page extremes miss, fill_frame ignored on lookup
      '{ACT_LOOKUP, 20'h00000, 20'h00000, 1'b1, 1'b0, 20'h00000},
      '{ACT_LOOKUP, 20'hFFFFF, 20'hFFFFF, 1'b1, 1'b0, 20'h00000},
      // fills answer hit 0, frame 0
      '{ACT_FILL,   20'h00000, 20'hFFFFF, 1'b1, 1'b0, 20'h00000},
      '{ACT_FILL,   20'hFFFFF, 20'h00000, 1'b1, 1'b0, 20'h00000},
      '{ACT_LOOKUP, 20'h00000, 20'h00000, 1'b1, 1'b1, 20'hFFFFF},
      '{ACT_LOOKUP, 20'hFFFFF, 20'h00000, 1'b1, 1'b1, 20'h00000},
      // frame already held by page 0: that entry goes away
      '{ACT_FILL,   20'h12345, 20'hFFFFF, 1'b1, 1'b0, 20'h00000},
      '{ACT_LOOKUP, 20'h00000, 20'h00000, 1'b1, 1'b0, 20'h00000},
      '{ACT_LOOKUP, 20'h12345, 20'h00000, 1'b0, 1'b0, 20'h00000},
      // refill of a held page replaces it
      '{ACT_FILL,   20'h12345, 20'hABCDE, 1'b1, 1'b0, 20'h00000},
      '{ACT_LOOKUP, 20'h12345, 20'h00000, 1'b0, 1'b0, 20'h00000},
      '{ACT_FILL,   20'h5A5A5, 20'hA5A5A, 1'b1, 1'b0, 20'h00000},
      '{ACT_FILL,   20'hA5A5A, 20'h5A5A5, 1'b1, 1'b0, 20'h00000},
      // table full: this one evicts the oldest (page FFFFF)
      '{ACT_FILL,   20'h33333, 20'hCCCCC, 1'b1, 1'b0, 20'h00000},
      '{ACT_LOOKUP, 20'hFFFFF, 20'h00000, 1'b0, 1'b0, 20'h00000},
      '{ACT_LOOKUP, 20'h33333, 20'h00000, 1'b0, 1'b0, 20'h00000},
      // reserved code: no effect, answers zeros
      '{ACT_RSVD,   20'hFFFFF, 20'hFFFFF, 1'b1, 1'b0, 20'h00000},
      '{ACT_LOOKUP, 20'hA5A5A, 20'h00000, 1'b0, 1'b0, 20'h00000},
      '{ACT_FLUSH,  20'hFFFFF, 20'hFFFFF, 1'b1, 1'b0, 20'h00000},
      '{ACT_LOOKUP, 20'h33333, 20'h00000, 1'b1, 1'b0, 20'h00000},
      '{ACT_RSVD,   20'h00000, 20'h00000, 1'b1, 1'b0, 20'h00000}
   };

   // Register settings per random phase: {lru, size}. Covers size zero (acts
   // as 1), 31 (saturates to 16), and shrinking below current occupancy.
   logic [CSR_DATA_W:0] phase_cfg [N_PHASES] = '{
      {1'b1, 5'd16}, {1'b1, 5'd3}, {1'b0, 5'd0}, {1'b1, 5'd31},
      {1'b0, 5'd1},  {1'b1, 5'd5}, {1'b0, 5'd16}, {1'b1, 5'd1}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic int held_limit();
      if (cfg_size == '0) return 1;
      if (cfg_size > SLOTS) return SLOTS;
      return int'(cfg_size);
   endfunction

   function automatic void drop_entry(int s);
      if (!tbl_valid[s]) return;
      tbl_valid[s] = 1'b0;
      foreach (tbl_age[i]) begin
         if (tbl_age[i] == s) begin
            tbl_age.delete(i);
            break;
         end
      end
   endfunction

   function automatic xlat_type translate_predict(action_type act, page_type page,
                                                  frame_type frame);
      xlat_type res;
      int       lim;
      res = '0;
      case (act)
         ACT_LOOKUP: begin
            for (int s = 0; s < SLOTS; s++) begin
               if (tbl_valid[s] && tbl_page[s] == page) begin
                  res.hit = 1'b1;
                  res.frame = tbl_frame[s];
                  // LRU: a hit becomes the newest entry
                  if (cfg_lru) begin
                     drop_entry(s);
                     tbl_valid[s] = 1'b1;
                     tbl_age.push_back(s);
                  end
                  break;
               end
            end
         end
         ACT_FILL: begin
            lim = held_limit();
            // a page or a frame is never held twice
            for (int s = 0; s < SLOTS; s++)
               if (tbl_valid[s] && (tbl_frame[s] == frame || tbl_page[s] == page))
                  drop_entry(s);
            while (tbl_age.size() >= lim && tbl_age.size() > 0)
               drop_entry(tbl_age[0]);
            for (int s = 0; s < SLOTS; s++) begin
               if (!tbl_valid[s]) begin
                  tbl_valid[s] = 1'b1;
                  tbl_page[s] = page;
                  tbl_frame[s] = frame;
                  tbl_age.push_back(s);
                  break;
               end
            end
         end
         ACT_FLUSH: begin
            foreach (tbl_valid[s]) tbl_valid[s] = 1'b0;
            tbl_age.delete();
         end
         default: ;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // Per-word wait 0..10, with calm stretches of back-to-back words.
   function automatic int draw_gap(ref bit calm);
      if ($urandom_range(0, 99) < 4) calm = !calm;
      return calm ? 0 : $urandom_range(0, 10);
   endfunction

   bit send_calm;

   // Offer one word, wait for acceptance, then book its translation.
   task automatic send_word(action_type act, page_type page, frame_type frame,
                            logic typed, xlat_type typed_res, output logic hit);
      int       gap;
      xlat_type res;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= REQ_W'({frame, page, act});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      res = translate_predict(act, page, frame);
      pending_xlat.push_back(typed ? typed_res : res);
      hit = res.hit;
   endtask

   // Let the block finish everything before the registers change.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_xlat.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic program_regs(logic lru, logic [CSR_DATA_W-1:0] size);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_MODE;
      csr_wdata <= {{(CSR_DATA_W-1){1'b0}}, lru};
      @(posedge clock);
      csr_addr  <= CSR_SIZE;
      csr_wdata <= size;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_lru  = lru;
      cfg_size = size;
   endtask

   // Mostly lookup/fill-on-miss traffic over a small page pool, so hits,
   // evictions and LRU reordering all happen; the rest is stray lookups,
   // unsolicited fills, flushes and reserved codes.
   task automatic run_random(int n_words);
      page_type   pool [$];
      frame_type  frames [$];
      page_type   page, miss_page;
      frame_type  frame;
      action_type act;
      logic       hit;
      bit         have_miss;
      int         sel, n_pool;
      have_miss = 0;
      n_pool = held_limit() + $urandom_range(1, 6);
      repeat (n_pool) pool.push_back(page_type'($urandom));
      repeat (8) frames.push_back(frame_type'($urandom));
      for (int i = 0; i < n_words; i++) begin
         sel   = $urandom_range(0, 99);
         page  = pool[$urandom_range(0, n_pool - 1)];
         frame = ($urandom_range(0, 99) < 30) ? frames[$urandom_range(0, 7)]
                                              : frame_type'($urandom);
         if (have_miss && sel < 80) begin
            act  = ACT_FILL;
            page = miss_page;
         end else if (sel < 60) begin
            act = ACT_LOOKUP;
            frame = ($urandom_range(0, 1) == 1) ? frame : '0;
         end else if (sel < 84) begin
            act = ACT_FILL;
         end else if (sel < 90) begin
            act  = ACT_LOOKUP;
            page = page_type'($urandom);
         end else if (sel < 94) begin
            act  = ACT_FILL;
            page = page_type'($urandom);
         end else if (sel < 96) begin
            act = ACT_FLUSH;
         end else begin
            act  = ACT_RSVD;
            page = page_type'($urandom);
         end
         send_word(act, page, frame, 1'b0, '0, hit);
         have_miss = (act == ACT_LOOKUP) && !hit;
         miss_page = page;
      end
   endtask

   initial begin
      logic hit;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_MODE;
      csr_wdata  <= '0;
      send_calm  = 0;
      cfg_lru    = 1'b0;
      cfg_size   = SIZE_RESET;
      foreach (tbl_valid[s]) tbl_valid[s] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_word(dir_rows[i].act, dir_rows[i].page, dir_rows[i].frame,
                   dir_rows[i].typed, {dir_rows[i].hit, dir_rows[i].frame_out}, hit);

      // each phase starts from an idle block; the table carries over
      foreach (phase_cfg[p]) begin
         drain();
         program_regs(phase_cfg[p][CSR_DATA_W], phase_cfg[p][CSR_DATA_W-1:0]);
         run_random(PHASE_WORDS);
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver side: random stalls, plus one long hold-off so the input
   // backs up while the sender keeps offering words.
   // ---------------------------------------------------------------------

   initial begin
      bit recv_calm;
      bit held;
      int gap, taken;
      recv_calm = 0;
      held = 0;
      taken = 0;
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (!held && taken >= HOLD_AT) begin
            held = 1;
            gap = HOLD_LEN;
         end else begin
            gap = draw_gap(recv_calm);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
      end
   end

   // ---------------------------------------------------------------------
   // Result check and stall counter
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      xlat_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_xlat.size() == 0) begin
               $error("result word with no translation outstanding: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = pending_xlat.pop_front();
               if (rsp_tdata[0] !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_tdata[0]);
                  mismatches++;
               end
               if (rsp_tdata[FRAME_W:1] !== want.frame) begin
                  $error("frame_number: expected %h, got %h", want.frame,
                         rsp_tdata[FRAME_W:1]);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

endmodule
